// ----- sv/psd_pkg.sv -----
// Shared types and constants for the pairwise squared distance block.
`timescale 1ns / 1ps

package psd_pkg;

  // Default capacity of the reference bank
  localparam int unsigned MAX_REFS_DEFAULT = 64;
  localparam int unsigned MAX_DIM_DEFAULT  = 64;

  localparam int unsigned ACC_W  = 38;
  localparam int unsigned VAL_W  = 16;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  // Register indexes (paddr[2])
  localparam logic REG_DIM_COUNT = 1'b0;
  localparam logic REG_REF_COUNT = 1'b1;

  // Request codes
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic                    req_type;
    logic [5:0]              ref_slot;
    logic [5:0]              dim_index;
    logic signed [VAL_W-1:0] value;
  } psd_in_t;

  typedef struct packed {
    logic [5:0]       ref_number;
    logic [ACC_W-1:0] distance;
    logic             last;
  } psd_out_t;

endpackage

// ----- sv/psd_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps

module psd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- sv/pairwise_squared_distance.sv -----
// Top level of the pairwise squared Euclidean distance block.
//
//  channel | direction | handshake                    | beat
//  --------+-----------+------------------------------+------------------------------
//  in      | in        | in_valid_i / in_stall_o      | psd_in_t: load or query element
//  out     | out       | out_valid_o / out_stall_i    | psd_out_t: one distance per ref
//  cfg     | in/out    | psel, penable, pwrite, pready| dim_count at 0, ref_count at 4
//
// A load beat writes the reference bank at once.
// A query beat holds in_stall_o from its accept while the shared subtract-square-add pipe
// walks every reference in use, one per cycle, drains its three stages, then sees it
// empty in ST_DRAIN; only then can the next beat go in.
// The final dimension of a query then emits refs beats through the output register,
// one per ST_OUT_RD, ST_OUT_LD pair; out_stall_i holds the sequencer, nothing is lost.
// Reset clears control state and the accumulator valid bits; the reference bank
// is undefined until written and needs no clearing pass.
`timescale 1ns / 1ps

module pairwise_squared_distance #(
  parameter int unsigned MAX_REFS = psd_pkg::MAX_REFS_DEFAULT,
  parameter int unsigned MAX_DIM  = psd_pkg::MAX_DIM_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  psd_pkg::psd_in_t              in_data_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output psd_pkg::psd_out_t             out_data_o,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [psd_pkg::ADDR_W-1:0]    paddr,
  input  logic [psd_pkg::DATA_W-1:0]    pwdata,
  output logic [psd_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  import psd_pkg::*;

  localparam int unsigned RW = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
  localparam int unsigned DW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned STORE_DEPTH = 2 ** (RW + DW);
  localparam logic [CNT_W-1:0] DIM_CAP = (MAX_DIM > 127) ? 7'd127 : 7'(MAX_DIM);
  localparam logic [CNT_W-1:0] REF_CAP = (MAX_REFS > 127) ? 7'd127 : 7'(MAX_REFS);
  localparam logic [ACC_W-1:0] ACC_MAX = '1;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_RUN    = 5'b00010,
    ST_DRAIN  = 5'b00100,
    ST_OUT_RD = 5'b01000,
    ST_OUT_LD = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [CNT_W-1:0] dim_count_q, ref_count_q;
  logic [CNT_W-1:0] dims, refs;
  logic             cfg_we;

  // query context
  logic [CNT_W-1:0]        r_q, r_d;
  logic [5:0]              dim_q;
  logic signed [VAL_W-1:0] qval_q;
  logic                    emit_q;

  // shared pipe
  logic             p1_q, p2_q, p3_q;
  logic [CNT_W-1:0] r1_q, r2_q, r3_q;
  logic [15:0]      mag_q;
  logic [31:0]      prod_q;
  logic signed [16:0] diff;
  logic [16:0]      diff_abs;
  logic [ACC_W:0]   sum_wide;
  logic [ACC_W-1:0] sum_sat;

  // accumulator valid bits: an entry not valid reads as zero
  logic [MAX_REFS-1:0] acc_vld_q, acc_vld_d;

  // memories
  logic                 st_we;
  logic [RW+DW-1:0]     st_waddr, st_raddr;
  logic [VAL_W-1:0]     st_rdata;
  logic [RW-1:0]        acc_raddr;
  logic [ACC_W-1:0]     acc_rdata, acc_val;

  // output register
  logic     out_vld_q;
  psd_out_t out_q;

  logic in_acc, out_acc, q_ok;

  // ---------------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_count_q <= 7'd1;
      ref_count_q <= 7'd1;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_DIM_COUNT: dim_count_q <= pwdata[CNT_W-1:0];
        REG_REF_COUNT: ref_count_q <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_DIM_COUNT: prdata = {{(DATA_W-CNT_W){1'b0}}, dim_count_q};
      REG_REF_COUNT: prdata = {{(DATA_W-CNT_W){1'b0}}, ref_count_q};
      default:       prdata = '0;
    endcase
  end

  // zero acts as one, anything above capacity saturates
  assign dims = (dim_count_q == '0) ? 7'd1 :
                (dim_count_q > DIM_CAP) ? DIM_CAP : dim_count_q;
  assign refs = (ref_count_q == '0) ? 7'd1 :
                (ref_count_q > REF_CAP) ? REF_CAP : ref_count_q;

  // ---------------------------------------------------------------------------
  // handshakes
  // ---------------------------------------------------------------------------
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;
  assign out_acc     = out_vld_q && !out_stall_i;
  assign q_ok        = ({1'b0, in_data_i.dim_index} < dims);

  // ---------------------------------------------------------------------------
  // reference bank
  // ---------------------------------------------------------------------------
  assign st_we = in_acc && (in_data_i.req_type == REQ_LOAD) &&
                 (32'(in_data_i.ref_slot) < MAX_REFS) &&
                 (32'(in_data_i.dim_index) < MAX_DIM);
  assign st_waddr = {RW'(in_data_i.ref_slot), DW'(in_data_i.dim_index)};
  assign st_raddr = {RW'(r_q), DW'(dim_q)};

  psd_ram #(
    .WIDTH (VAL_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (in_data_i.value),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  // ---------------------------------------------------------------------------
  // accumulators: read in stage 2 so the data meets the square in stage 3
  // ---------------------------------------------------------------------------
  assign acc_raddr = p2_q ? RW'(r2_q) : RW'(r_q);

  psd_ram #(
    .WIDTH (ACC_W),
    .DEPTH (MAX_REFS)
  ) u_acc (
    .clk_i   (clk_i),
    .we_i    (p3_q),
    .waddr_i (RW'(r3_q)),
    .wdata_i (sum_sat),
    .raddr_i (acc_raddr),
    .rdata_o (acc_rdata)
  );

  // ---------------------------------------------------------------------------
  // shared subtract-square-add pipe
  // ---------------------------------------------------------------------------
  assign diff     = {st_rdata[VAL_W-1], st_rdata} - {qval_q[VAL_W-1], qval_q};
  assign diff_abs = diff[16] ? 17'(-diff) : 17'(diff);
  assign acc_val  = acc_vld_q[RW'(r3_q)] ? acc_rdata : '0;
  assign sum_wide = {1'b0, acc_val} + {{(ACC_W+1-32){1'b0}}, prod_q};
  assign sum_sat  = sum_wide[ACC_W] ? ACC_MAX : sum_wide[ACC_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_q <= 1'b0;
      p2_q <= 1'b0;
      p3_q <= 1'b0;
    end else begin
      p1_q <= (state_q == ST_RUN);
      p2_q <= p1_q;
      p3_q <= p2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    r1_q   <= r_q;
    r2_q   <= r1_q;
    r3_q   <= r2_q;
    mag_q  <= diff_abs[15:0];
    prod_q <= {16'b0, mag_q} * {16'b0, mag_q};
  end

  always_comb begin
    acc_vld_d = acc_vld_q;
    if (in_acc && (in_data_i.req_type == REQ_QUERY) && q_ok &&
        (in_data_i.dim_index == '0)) begin
      acc_vld_d = '0;
    end
    if (p3_q) begin
      acc_vld_d[RW'(r3_q)] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_vld_q <= '0;
    end else begin
      acc_vld_q <= acc_vld_d;
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    r_d     = r_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_data_i.req_type == REQ_QUERY) && q_ok) begin
          state_d = ST_RUN;
          r_d     = '0;
        end
      end
      ST_RUN: begin
        if (r_q == refs - 7'd1) begin
          state_d = ST_DRAIN;
          r_d     = '0;
        end else begin
          r_d = r_q + 7'd1;
        end
      end
      ST_DRAIN: begin
        if (!p1_q && !p2_q && !p3_q) begin
          state_d = emit_q ? ST_OUT_RD : ST_IDLE;
        end
      end
      ST_OUT_RD: begin
        // output register free by the next edge
        if (!out_vld_q || out_acc) begin
          state_d = ST_OUT_LD;
        end
      end
      ST_OUT_LD: begin
        if (r_q == refs - 7'd1) begin
          state_d = ST_IDLE;
        end else begin
          r_d     = r_q + 7'd1;
          state_d = ST_OUT_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      r_q     <= '0;
    end else begin
      state_q <= state_d;
      r_q     <= r_d;
    end
  end

  // query context, latched on accept
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dim_q  <= in_data_i.dim_index;
      qval_q <= in_data_i.value;
      emit_q <= ({1'b0, in_data_i.dim_index} == dims - 7'd1);
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (state_q == ST_OUT_LD) begin
      out_vld_q <= 1'b1;
    end else if (out_acc) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT_LD) begin
      out_q.ref_number <= 6'(r_q);
      out_q.distance   <= acc_vld_q[RW'(r_q)] ? acc_rdata : '0;
      out_q.last       <= (r_q == refs - 7'd1);
    end
  end

endmodule

// ----- tb/pairwise_squared_distance_tb.sv -----
// Self-checking testbench for pairwise_squared_distance: directed and random beats vs a predictor.
`timescale 1ns / 1ps

module pairwise_squared_distance_tb;
  import psd_pkg::*;

  localparam int BANK_REFS = MAX_REFS_DEFAULT;
  localparam int BANK_DIM  = MAX_DIM_DEFAULT;
  localparam longint unsigned SUM_MAX = (64'd1 << ACC_W) - 64'd1;
  // Even with 64 distances per beat under heavy stalls a run stays below this limit.
  localparam int CYCLE_LIMIT = 1_000_000;
  // A query beat keeps the block busy while it walks every reference, so 64 refs plus slack.
  localparam int SETTLE_CYCLES = 120;
  localparam int MAX_REPORTS = 40;

  typedef enum int {STALL_NONE, STALL_SPARSE, STALL_PERIODIC, STALL_COIN} stall_mode_e;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  psd_in_t             in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  psd_out_t            out_data_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [ADDR_W-1:0]   paddr       = '0;
  logic [DATA_W-1:0]   pwdata      = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  pairwise_squared_distance dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: reference bank, running sums, raw register copies
  // ---------------------------------------------------------------------------
  logic signed [VAL_W-1:0] ref_bank     [BANK_REFS][BANK_DIM];
  bit                      bank_written [BANK_REFS][BANK_DIM];
  logic [ACC_W-1:0]        dist_sum     [BANK_REFS];
  logic [CNT_W-1:0]        dim_reg = CNT_W'(1);
  logic [CNT_W-1:0]        ref_reg = CNT_W'(1);
  psd_out_t                pending_distances [$];

  int          fault_count   = 0;
  int          counted_beats = 0;   // beats that do something (ignored queries excluded)
  int          burst_left    = 0;
  int unsigned cycle_count   = 0;

  initial begin
    foreach (dist_sum[r]) dist_sum[r] = '0;
  end

  // Zero acts as one, anything above the bank size saturates to it.
  function automatic int clamp_count(logic [CNT_W-1:0] raw, int cap);
    if (raw == 0) return 1;
    return (int'(raw) > cap) ? cap : int'(raw);
  endfunction

  // Works out the distance beats that an accepted input beat causes.
  task automatic predict_distances(psd_in_t beat);
    int dims;
    int refs;
    int q;
    int a;
    int diff;
    longint unsigned mag;
    longint unsigned sum;
    psd_out_t res;
    dims = clamp_count(dim_reg, BANK_DIM);
    refs = clamp_count(ref_reg, BANK_REFS);
    if (beat.req_type == REQ_LOAD) begin
      ref_bank[beat.ref_slot][beat.dim_index]     = beat.value;
      bank_written[beat.ref_slot][beat.dim_index] = 1'b1;
      counted_beats++;
      return;
    end
    if (int'(beat.dim_index) >= dims) return;   // beyond the dimension count
    counted_beats++;
    if (beat.dim_index == 0) begin
      foreach (dist_sum[r]) dist_sum[r] = '0;
    end
    q = $signed(beat.value);
    for (int r = 0; r < refs; r++) begin
      a    = ref_bank[r][beat.dim_index];
      diff = a - q;
      mag  = (diff < 0) ? -diff : diff;
      sum  = 64'(dist_sum[r]) + mag * mag;
      dist_sum[r] = (sum > SUM_MAX) ? SUM_MAX[ACC_W-1:0] : sum[ACC_W-1:0];
    end
    if (int'(beat.dim_index) != dims - 1) return;
    for (int r = 0; r < refs; r++) begin
      res.ref_number = 6'(r);
      res.distance   = dist_sum[r];
      res.last       = (r == refs - 1);
      pending_distances.push_back(res);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input side: bursts of beats with random gaps between them
  // ---------------------------------------------------------------------------
  task automatic send_beat(psd_in_t beat);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? 120 : $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (in_stall_o);
    predict_distances(beat);
  endtask

  task automatic load_elem(int slot, int dim, logic [VAL_W-1:0] v);
    psd_in_t b;
    b.req_type  = REQ_LOAD;
    b.ref_slot  = 6'(slot);
    b.dim_index = 6'(dim);
    b.value     = v;
    send_beat(b);
  endtask

  // ref_slot is don't-care on a query, so it gets noise
  task automatic query_elem(int dim, logic [VAL_W-1:0] v);
    psd_in_t b;
    b.req_type  = REQ_QUERY;
    b.ref_slot  = 6'($urandom_range(0, 63));
    b.dim_index = 6'(dim);
    b.value     = v;
    send_beat(b);
  endtask

  // Biased towards the Q8.8 extremes
  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Every element a query can read must have been written first.
  task automatic fill_bank(int refs, int dims);
    for (int r = 0; r < refs; r++)
      for (int d = 0; d < dims; d++)
        if (!bank_written[r][d]) load_elem(r, d, rand_value());
  endtask

  // Lower valid, let every pending distance out, then let the pipe empty.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_distances.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Configuration port: write, then read back
  // ---------------------------------------------------------------------------
  task automatic set_register(logic regsel, logic [CNT_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {regsel, 2'b00};
    pwdata  <= DATA_W'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (regsel == REG_DIM_COUNT) dim_reg = v;
    else ref_reg = v;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== DATA_W'(v)) begin
      fault_count++;
      if (fault_count <= MAX_REPORTS)
        $display("%0t ns: register %0d read back, expected %0h, actual %0h",
                 $time, regsel, DATA_W'(v), prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(int dims_raw, int refs_raw);
    wait_idle();
    set_register(REG_DIM_COUNT, CNT_W'(dims_raw));
    set_register(REG_REF_COUNT, CNT_W'(refs_raw));
  endtask

  // ---------------------------------------------------------------------------
  // Output side: stall pattern and result check
  // ---------------------------------------------------------------------------
  stall_mode_e stall_mode  = STALL_NONE;
  int          stall_hold  = 0;
  int unsigned stall_phase = 0;

  always @(posedge clk_i) begin
    if (stall_hold == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_hold = $urandom_range(16, 256);
    end
    stall_hold--;
    stall_phase++;
    case (stall_mode)
      STALL_NONE:     out_stall_i <= 1'b0;
      STALL_SPARSE:   out_stall_i <= ($urandom_range(0, 3) == 0);
      STALL_PERIODIC: out_stall_i <= ((stall_phase % 7) < 5);
      default:        out_stall_i <= ($urandom_range(0, 1) == 0);
    endcase
  end

  task automatic report_field(string field, logic [63:0] want, logic [63:0] got);
    fault_count++;
    if (fault_count <= MAX_REPORTS)
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
  endtask

  psd_out_t want_beat;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_distances.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS)
          $display("%0t ns: distance beat with nothing pending, expected none, actual %0h",
                   $time, out_data_o);
      end else begin
        want_beat = pending_distances.pop_front();
        if (out_data_o.ref_number !== want_beat.ref_number)
          report_field("ref_number", want_beat.ref_number, out_data_o.ref_number);
        if (out_data_o.distance !== want_beat.distance)
          report_field("distance", want_beat.distance, out_data_o.distance);
        if (out_data_o.last !== want_beat.last)
          report_field("last", want_beat.last, out_data_o.last);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t ns: timeout, %0d distances still pending", $time, pending_distances.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // One dimension, one reference (reset setting): largest and smallest differences.
  task automatic test_value_extremes();
    load_elem(0, 0, 16'h8000);
    query_elem(0, 16'h7FFF);             // full-scale difference, 65535^2
    load_elem(0, 0, 16'h7FFF);
    query_elem(0, 16'h8000);
    load_elem(0, 0, 16'h0000);
    query_elem(0, 16'h0000);             // zero distance
    query_elem(0, 16'hFFFF);             // one LSB
    load_elem(63, 63, 16'hFFFF);         // top slot and top dimension
    load_elem(63, 63, 16'h5555);
    query_elem(1, 16'h1234);             // beyond the dimension count: no effect
    query_elem(63, 16'h7FFF);
    query_elem(0, 16'h0100);
    wait_idle();
  endtask

  // Zero counts act as one; counts above the bank size saturate.
  task automatic test_register_limits();
    configure(0, 0);
    query_elem(0, 16'h8000);
    configure(127, 1);
    load_elem(0, 63, 16'h7FFF);
    query_elem(63, 16'h8000);            // last dimension alone: old sums carry over
    query_elem(0, 16'h0080);
    query_elem(63, 16'hFF00);
    configure(1, 127);
    fill_bank(BANK_REFS, 1);
    query_elem(0, 16'h8000);             // one distance per reference, all 64
    query_elem(0, 16'h7FFF);
    wait_idle();
  endtask

  // Elements out of order, repeated dimension zero, skipped dimension zero.
  task automatic test_out_of_order();
    configure(4, 3);
    fill_bank(3, 4);
    query_elem(1, rand_value());
    query_elem(2, rand_value());
    query_elem(3, rand_value());
    query_elem(0, rand_value());
    query_elem(0, rand_value());
    query_elem(3, rand_value());
    query_elem(2, rand_value());
    query_elem(1, rand_value());
    query_elem(0, rand_value());
    query_elem(3, rand_value());
    query_elem(4, rand_value());         // out of range: ignored
    query_elem(3, rand_value());
    wait_idle();
  endtask

  // Mostly well-formed queries; some reloads, stray elements and cut-short queries.
  task automatic run_random_phase(int dims_raw, int refs_raw, int budget);
    int dims;
    int refs;
    int start;
    int pick;
    int cut;
    configure(dims_raw, refs_raw);
    dims = clamp_count(CNT_W'(dims_raw), BANK_DIM);
    refs = clamp_count(CNT_W'(refs_raw), BANK_REFS);
    fill_bank(refs, dims);
    start = counted_beats;
    while (counted_beats - start < budget) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        for (int d = 0; d < dims; d++) query_elem(d, rand_value());
      end else if (pick == 7) begin
        load_elem($urandom_range(0, 63), $urandom_range(0, 63), rand_value());
      end else if (pick == 8) begin
        query_elem($urandom_range(0, 63), rand_value());
      end else begin
        cut = $urandom_range(0, dims - 1);
        for (int d = 0; d < cut; d++) query_elem(d, rand_value());
      end
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(127, 1, 40);
    run_random_phase(1, 64, 24);
    run_random_phase(2, 5, 20);
    run_random_phase($urandom_range(1, 6), $urandom_range(1, 6), 20);
    run_random_phase(0, $urandom_range(1, 127), 16);
    wait_idle();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_value_extremes();
    test_register_limits();
    test_out_of_order();
    test_random_traffic();
    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- pairwise_squared_distance.f -----
sv/psd_pkg.sv
sv/psd_ram.sv
sv/pairwise_squared_distance.sv
tb/pairwise_squared_distance_tb.sv
